// ===== rtl/core/quat_to_euler_zyx_macros.svh =====
// assertion macros for the quaternion to euler angle block
// expects clk_i and rst_ni in the scope of each use
`ifndef QUAT_TO_EULER_ZYX_MACROS_SVH
`define QUAT_TO_EULER_ZYX_MACROS_SVH

// same-cycle implication, quiet during reset
`define Q2E_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define Q2E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/q2e_pkg.sv =====
// shared types, widths and tables for the quaternion to euler angle block
// no dependencies
package q2e_pkg;

  localparam int QUAT_FRAC_BITS = 14;
  localparam int CORDIC_STEPS   = 16;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int CORDIC_N       = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS
                                                                  : ATAN_TABLE_LEN;

  localparam int Q_W        = 16;
  localparam int PROD_W     = 2 * Q_W;
  localparam int ONE_SHIFT  = 2 * QUAT_FRAC_BITS;
  localparam int SUM_W      = (ONE_SHIFT + 3 > 35) ? ONE_SHIFT + 3 : 35;
  localparam int NORM_W     = SUM_W + 1;
  localparam int NORM_TOP   = 30;
  localparam int RSH_BITS   = $clog2(NORM_W - NORM_TOP);
  localparam int LSH_BITS   = 5;
  localparam int NORM_STAGES = RSH_BITS + LSH_BITS;
  localparam int CW         = 34;
  localparam int ZW         = 34;
  localparam int SN_W       = 31;
  localparam int SQ_W       = 2 * (SN_W - 1) + 1;
  localparam int SQRT_STAGES = SN_W;
  localparam int SQRT_LAT   = SQRT_STAGES + 1;
  localparam int CORDIC_LAT = 1 + NORM_STAGES + CORDIC_N;
  localparam int ANG_W      = 16;

  // pi/2 as a 16-bit binary angle, and as an accumulator angle
  localparam logic signed [ANG_W-1:0] PITCH_MAX = 16'sd16384;
  localparam logic signed [ZW-1:0]    HALF_PI_Z = ZW'(64'sd1 <<< 30);

  // round(atan(2^-i) * 2^31 / pi)
  localparam logic [31:0] ATAN_TAB [ATAN_TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [Q_W-1:0] qw;
    logic signed [Q_W-1:0] qx;
    logic signed [Q_W-1:0] qy;
    logic signed [Q_W-1:0] qz;
  } in_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] yaw_angle;
    logic signed [ANG_W-1:0] pitch_angle;
    logic signed [ANG_W-1:0] roll_angle;
    logic                    pitch_clamped;
  } out_t;

  // roll and yaw operands
  typedef struct packed {
    logic signed [SUM_W-1:0] sr;
    logic signed [SUM_W-1:0] cr;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] cy;
  } ry_t;

  // pitch operands and flags
  typedef struct packed {
    logic signed [SN_W-1:0] sn;
    logic        [SN_W-1:0] c;
    logic                   clamped;
    logic                   s_pos;
  } pit_t;

  typedef struct packed {
    ry_t  ry;
    pit_t pit;
  } ops_t;

endpackage

// ===== rtl/core/q2e_prod.sv =====
// product and sum stages: quaternion to atan2 operands and the pitch sine
// depends on q2e_pkg
module q2e_prod (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  q2e_pkg::in_t  data_i,
  output logic          valid_o,
  output q2e_pkg::ops_t ops_o
);
  import q2e_pkg::*;

  localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1) <<< ONE_SHIFT;

  logic signed [PROD_W-1:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  logic                     v1_q, v2_q;
  ops_t                     ops_q, ops_d;
  logic signed [SUM_W-1:0]  s;
  logic        [SUM_W-1:0]  s_mag;
  logic                     clamped;
  logic signed [SUM_W-1:0]  sn_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // stage 1: the nine products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= data_i.qw * data_i.qx;
      yz_q <= data_i.qy * data_i.qz;
      xx_q <= data_i.qx * data_i.qx;
      yy_q <= data_i.qy * data_i.qy;
      wz_q <= data_i.qw * data_i.qz;
      xy_q <= data_i.qx * data_i.qy;
      zz_q <= data_i.qz * data_i.qz;
      wy_q <= data_i.qw * data_i.qy;
      zx_q <= data_i.qz * data_i.qx;
    end
  end

  assign s       = (SUM_W'(wy_q) - SUM_W'(zx_q)) <<< 1;
  assign s_mag   = s[SUM_W-1] ? unsigned'(-s) : unsigned'(s);
  assign clamped = (s_mag >= unsigned'(ONE_S));

  // sine brought to 30 fraction bits
  if (ONE_SHIFT >= NORM_TOP) begin : g_sn_right
    logic [SUM_W-1:0] sh;
    assign sh      = s_mag >> (ONE_SHIFT - NORM_TOP);
    assign sn_full = s[SUM_W-1] ? -signed'(sh) : signed'(sh);
  end else begin : g_sn_left
    assign sn_full = s <<< (NORM_TOP - ONE_SHIFT);
  end

  // stage 2: sums and the saturation test
  always_comb begin
    ops_d.ry.sr = (SUM_W'(wx_q) + SUM_W'(yz_q)) <<< 1;
    ops_d.ry.cr = ONE_S - ((SUM_W'(xx_q) + SUM_W'(yy_q)) <<< 1);
    ops_d.ry.sy = (SUM_W'(wz_q) + SUM_W'(xy_q)) <<< 1;
    ops_d.ry.cy = ONE_S - ((SUM_W'(yy_q) + SUM_W'(zz_q)) <<< 1);
    ops_d.pit.sn      = clamped ? '0 : SN_W'(sn_full);
    ops_d.pit.c       = '0;
    ops_d.pit.clamped = clamped;
    ops_d.pit.s_pos   = ~s[SUM_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ops_q <= ops_d;
    end
  end

  assign valid_o = v2_q;
  assign ops_o   = ops_q;

endmodule

// ===== rtl/core/q2e_sqrt.sv =====
// pipelined square root for the pitch cosine, one result bit per stage
// depends on q2e_pkg
module q2e_sqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  q2e_pkg::pit_t pit_i,
  output logic          valid_o,
  output q2e_pkg::pit_t pit_o
);
  import q2e_pkg::*;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W:0]   root;
    pit_t            pit;
  } sq_t;

  sq_t              st_q [SQRT_STAGES+1];
  logic             v_q  [SQRT_STAGES+1];
  logic [SN_W-2:0]  mag;
  logic [SQ_W-2:0]  sq;

  assign mag = pit_i.sn[SN_W-1] ? (SN_W-1)'(-pit_i.sn) : pit_i.sn[SN_W-2:0];
  assign sq  = mag * mag;

  // stage 0: radicand 1 - s^2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].rem  <= (SQ_W'(1) << (SQ_W - 1)) - SQ_W'(sq);
      st_q[0].root <= '0;
      st_q[0].pit  <= pit_i;
    end
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
    localparam logic [SQ_W:0] BIT = (SQ_W + 1)'(1) << (2 * (SQRT_STAGES - 1 - k));
    sq_t           nx;
    logic [SQ_W:0] trial;

    always_comb begin
      nx    = st_q[k];
      trial = st_q[k].root + BIT;
      if ({1'b0, st_q[k].rem} >= trial) begin
        nx.rem  = st_q[k].rem - SQ_W'(trial);
        nx.root = (st_q[k].root >> 1) + BIT;
      end else begin
        nx.root = st_q[k].root >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1] <= nx;
      end
    end
  end

  always_comb begin
    pit_o   = st_q[SQRT_STAGES].pit;
    pit_o.c = st_q[SQRT_STAGES].root[SN_W-1:0];
  end
  assign valid_o = v_q[SQRT_STAGES];

endmodule

// ===== rtl/core/q2e_cordic.sv =====
// pipelined atan2: quadrant fold, normalising shifts, vectoring micro-rotations
// depends on q2e_pkg
module q2e_cordic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [q2e_pkg::SUM_W-1:0] y_i,
  input  logic signed [q2e_pkg::SUM_W-1:0] x_i,
  output logic                           valid_o,
  output logic signed [q2e_pkg::ZW-1:0]  z_o
);
  import q2e_pkg::*;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic        [NORM_W-1:0] m;
    logic signed [ZW-1:0]     z;
    logic                     zero;
  } norm_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } rot_t;

  function automatic logic signed [NORM_W-1:0] shr_n(input logic signed [NORM_W-1:0] v,
                                                      input int s);
    logic [NORM_W-1:0] a;
    a = v[NORM_W-1] ? unsigned'(-v) : unsigned'(v);
    a = a >> s;
    return v[NORM_W-1] ? -signed'(a) : signed'(a);
  endfunction

  function automatic logic signed [CW-1:0] shr_c(input logic signed [CW-1:0] v,
                                                  input int s);
    logic [CW-1:0] a;
    a = v[CW-1] ? unsigned'(-v) : unsigned'(v);
    a = a >> s;
    return v[CW-1] ? -signed'(a) : signed'(a);
  endfunction

  norm_t nrm_q [NORM_STAGES+1];
  logic  nv_q  [NORM_STAGES+1];
  rot_t  rot_q [CORDIC_N];
  logic  rv_q  [CORDIC_N];
  norm_t pre_d;

  // fold the left half plane by a quarter turn
  always_comb begin
    logic signed [NORM_W-1:0] xe, ye;
    logic        [NORM_W-1:0] ax, ay;
    xe = NORM_W'(x_i);
    ye = NORM_W'(y_i);
    pre_d.zero = (x_i == '0) && (y_i == '0);
    pre_d.x = xe;
    pre_d.y = ye;
    pre_d.z = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        pre_d.x = ye;
        pre_d.y = -xe;
        pre_d.z = HALF_PI_Z;
      end else begin
        pre_d.x = -ye;
        pre_d.y = xe;
        pre_d.z = -HALF_PI_Z;
      end
    end
    ax = pre_d.x[NORM_W-1] ? unsigned'(-pre_d.x) : unsigned'(pre_d.x);
    ay = pre_d.y[NORM_W-1] ? unsigned'(-pre_d.y) : unsigned'(pre_d.y);
    pre_d.m = (ax > ay) ? ax : ay;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q[0] <= 1'b0;
    end else if (en_i) begin
      nv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nrm_q[0] <= pre_d;
    end
  end

  // right shifts first, then left, until the larger magnitude sits in [2^29, 2^30)
  for (genvar k = 1; k <= NORM_STAGES; k++) begin : g_norm
    norm_t nx;
    if (k <= RSH_BITS) begin : g_right
      localparam int  AMT  = 1 << (RSH_BITS - k);
      localparam bit  LIVE = (NORM_TOP - 1 + AMT) < NORM_W;
      localparam logic [NORM_W-1:0] LIM = NORM_W'(1) << (LIVE ? NORM_TOP - 1 + AMT : 0);
      always_comb begin
        nx = nrm_q[k-1];
        if (LIVE && (nrm_q[k-1].m >= LIM)) begin
          nx.x = shr_n(nrm_q[k-1].x, AMT);
          nx.y = shr_n(nrm_q[k-1].y, AMT);
          nx.m = nrm_q[k-1].m >> AMT;
        end
      end
    end else begin : g_left
      localparam int AMT = 1 << (NORM_STAGES - k);
      localparam logic [NORM_W-1:0] LIM = NORM_W'(1) << (NORM_TOP - AMT);
      always_comb begin
        nx = nrm_q[k-1];
        if (nrm_q[k-1].m < LIM) begin
          nx.x = nrm_q[k-1].x <<< AMT;
          nx.y = nrm_q[k-1].y <<< AMT;
          nx.m = nrm_q[k-1].m << AMT;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[k] <= 1'b0;
      end else if (en_i) begin
        nv_q[k] <= nv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nrm_q[k] <= nx;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ANG = ZW'(signed'({1'b0, ATAN_TAB[i]}));
    rot_t src, nx;
    logic vin;
    logic signed [CW-1:0] xs, ys;

    if (i == 0) begin : g_first
      always_comb begin
        src.x    = CW'(nrm_q[NORM_STAGES].x);
        src.y    = CW'(nrm_q[NORM_STAGES].y);
        src.z    = nrm_q[NORM_STAGES].z;
        src.zero = nrm_q[NORM_STAGES].zero;
      end
      assign vin = nv_q[NORM_STAGES];
    end else begin : g_next
      assign src = rot_q[i-1];
      assign vin = rv_q[i-1];
    end

    assign xs = shr_c(src.x, i);
    assign ys = shr_c(src.y, i);

    always_comb begin
      nx = src;
      if (src.y >= 0) begin
        nx.x = src.x + ys;
        nx.y = src.y - xs;
        nx.z = src.z + ANG;
      end else begin
        nx.x = src.x - ys;
        nx.y = src.y + xs;
        nx.z = src.z - ANG;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[i] <= 1'b0;
      end else if (en_i) begin
        rv_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rot_q[i] <= nx;
      end
    end
  end

  // the zero vector gives angle zero
  assign z_o     = rot_q[CORDIC_N-1].zero ? '0 : rot_q[CORDIC_N-1].z;
  assign valid_o = rv_q[CORDIC_N-1];

endmodule

// ===== rtl/core/quat_to_euler_zyx.sv =====
// top level: quaternion (q2.14) in, zyx euler binary angles out
// depends on q2e_pkg, q2e_prod, q2e_sqrt, q2e_cordic, quat_to_euler_zyx_macros.svh
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_ready_o    in_data_i  (qw, qx, qy, qz)
//  out      output     out_valid_o / out_ready_i  out_data_o (yaw, pitch, roll, clamp flag)
//
// one item enters per cycle while the output is not stalled
// on the pitch path each item passes through 2 product/sum stages, 32 square-root stages,
// 25 atan2 stages (fold, normalise, 16 micro-rotations) and the output register
// reset clears every valid bit; payload registers are not reset
// a stalled output freezes the whole pipeline in place, so nothing is dropped or repeated
module quat_to_euler_zyx (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  q2e_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output q2e_pkg::out_t out_data_o
);
  import q2e_pkg::*;
  `include "quat_to_euler_zyx_macros.svh"

  typedef struct packed {
    logic clamped;
    logic s_pos;
  } flag_t;

  // global advance: the pipeline moves whenever the output register can take an item
  logic en;

  logic  prod_valid, sqrt_valid;
  ops_t  ops;
  pit_t  pit;

  ry_t   ry_q  [SQRT_LAT];
  flag_t flg_q [CORDIC_LAT];

  logic                 pitch_valid, roll_valid, yaw_valid;
  logic signed [ZW-1:0] pitch_z, roll_z, yaw_z;

  logic                 out_valid_q;
  out_t                 out_q, out_d;

  assign en         = ~out_valid_q | out_ready_i;
  assign in_ready_o = en;

  // products, sums and the pitch sine
  q2e_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (prod_valid),
    .ops_o   (ops)
  );

  // pitch cosine
  q2e_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prod_valid),
    .pit_i   (ops.pit),
    .valid_o (sqrt_valid),
    .pit_o   (pit)
  );

  // roll and yaw operands wait alongside the square root
  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_ry_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        ry_q[k] <= (k == 0) ? ops.ry : ry_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // saturation flags wait alongside the atan2 units
  for (genvar k = 0; k < CORDIC_LAT; k++) begin : g_flag_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (k == 0) begin
          flg_q[k] <= '{clamped: pit.clamped, s_pos: pit.s_pos};
        end else begin
          flg_q[k] <= flg_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // three atan2 units running in lock step
  q2e_cordic u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .y_i     (SUM_W'(pit.sn)),
    .x_i     (signed'(SUM_W'(pit.c))),
    .valid_o (pitch_valid),
    .z_o     (pitch_z)
  );

  q2e_cordic u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .y_i     (ry_q[SQRT_LAT-1].sr),
    .x_i     (ry_q[SQRT_LAT-1].cr),
    .valid_o (roll_valid),
    .z_o     (roll_z)
  );

  q2e_cordic u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .y_i     (ry_q[SQRT_LAT-1].sy),
    .x_i     (ry_q[SQRT_LAT-1].cy),
    .valid_o (yaw_valid),
    .z_o     (yaw_z)
  );

  // round to 16-bit binary angles; pitch is clamped to a quarter turn
  always_comb begin
    logic signed [ZW-1:0] yaw_r, roll_r, pitch_r, pitch_s;
    yaw_r   = yaw_z + ZW'(32768);
    roll_r  = roll_z + ZW'(32768);
    pitch_r = pitch_z + ZW'(32768);
    pitch_s = pitch_r >>> 16;
    out_d.yaw_angle     = yaw_r[31:16];
    out_d.roll_angle    = roll_r[31:16];
    out_d.pitch_clamped = flg_q[CORDIC_LAT-1].clamped;
    priority if (flg_q[CORDIC_LAT-1].clamped) begin
      out_d.pitch_angle = flg_q[CORDIC_LAT-1].s_pos ? PITCH_MAX : -PITCH_MAX;
    end else if (pitch_s > ZW'(PITCH_MAX)) begin
      out_d.pitch_angle = PITCH_MAX;
    end else if (pitch_s < -ZW'(PITCH_MAX)) begin
      out_d.pitch_angle = -PITCH_MAX;
    end else begin
      out_d.pitch_angle = pitch_s[ANG_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= pitch_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `Q2E_ASSERT_IMPL(a_units_aligned, 1'b1,
    (roll_valid == pitch_valid) && (yaw_valid == pitch_valid),
    "atan2 units out of step")
  `Q2E_ASSERT_IMPL(a_clamp_quarter, out_valid_o && out_data_o.pitch_clamped,
    (out_data_o.pitch_angle == PITCH_MAX) || (out_data_o.pitch_angle == -PITCH_MAX),
    "clamped pitch not a quarter turn")
  `Q2E_ASSERT_IMPL(a_pitch_range, out_valid_o,
    (out_data_o.pitch_angle <= PITCH_MAX) && (out_data_o.pitch_angle >= -PITCH_MAX),
    "pitch outside a quarter turn")
  `Q2E_ASSERT_IMPL(a_stall_holds_input, out_valid_o && !out_ready_i, !in_ready_o,
    "input taken while output stalled")

endmodule
